>>> hw/rtl/lik_pkg.sv
package lik_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REG_W     = 19;
    localparam int IO_W      = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CORD_W    = 25;
    localparam int ANG_W     = 22;

    localparam longint PI4_Q40 = 64'sd863554413089;
    localparam longint PI_Q40  = 64'sd3454217652358;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUND_HEIGHT = 3'd0,
        CFG_HIP_LEN       = 3'd1,
        CFG_THIGH_LEN     = 3'd2,
        CFG_SHANK_LEN     = 3'd3,
        CFG_THIGH_BIAS    = 3'd4,
        CFG_SHANK_BIAS    = 3'd5
    } cfg_idx_t;

    localparam logic [REG_W-1:0] RST_GROUND_HEIGHT = 19'd6554;
    localparam logic [REG_W-1:0] RST_HIP_LEN       = 19'd3277;
    localparam logic [REG_W-1:0] RST_THIGH_LEN     = 19'd5243;
    localparam logic [REG_W-1:0] RST_SHANK_LEN     = 19'd7864;
    localparam logic [REG_W-1:0] RST_THIGH_BIAS    = 19'd126386;
    localparam logic [REG_W-1:0] RST_SHANK_BIAS    = 19'd130397;

    typedef struct packed {
        logic signed [IO_W-1:0] tip_x;
        logic signed [IO_W-1:0] tip_y;
        logic signed [IO_W-1:0] tip_z;
    } in_t;

    typedef struct packed {
        logic signed [IO_W-1:0] hip_angle;
        logic signed [IO_W-1:0] thigh_angle;
        logic signed [IO_W-1:0] shank_angle;
        logic                   reachable;
    } out_t;

    function automatic longint div_small(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    function automatic longint atan_q40(input int i);
        longint sum;
        longint term;
        int     e;
        sum = 0;
        if (i == 0) begin
            return PI4_Q40;
        end
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 40) begin
                break;
            end
            term = div_small(64'sd1 <<< (40 - e), longint'(2 * k + 1));
            sum = ((k % 2) == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic longint q40_to_frac(input longint t);
        return (t + (64'sd1 <<< (39 - FRAC_BITS))) >>> (40 - FRAC_BITS);
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        longint v;
        v = q40_to_frac(atan_q40(i));
        return v[ANG_W-1:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] pi_frac();
        longint v;
        v = q40_to_frac(PI_Q40);
        return v[ANG_W-1:0];
    endfunction

endpackage

>>> hw/rtl/lik_delay.sv
module lik_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

>>> hw/rtl/lik_sqrt_cell.sv
module lik_sqrt_cell #(
    parameter int RW = 42,
    parameter int K  = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [RW:0]   res_in,
    output logic [RW-1:0] rem_out,
    output logic [RW:0]   res_out
);

    localparam logic [RW:0] BIT = {{RW{1'b0}}, 1'b1} << (2 * K);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW:0]   res_reg;
    logic [RW:0]   res_next;
    logic [RW:0]   trial;

    always_comb
    begin
        trial = res_in + BIT;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next = rem_in - trial[RW-1:0];
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;

endmodule

>>> hw/rtl/lik_div_cell.sv
module lik_div_cell #(
    parameter int DW = 42,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] d_in,
    input  logic [QW-1:0] q_in,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] d_out,
    output logic [QW-1:0] q_out
);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] d_reg;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;
    logic [DW-1:0] shifted;
    logic          ge;

    always_comb
    begin
        shifted  = {rem_in[DW-2:0], 1'b0};
        ge       = shifted >= d_in;
        rem_next = ge ? shifted - d_in : shifted;
        q_next   = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            d_reg   <= d_in;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign d_out   = d_reg;
    assign q_out   = q_reg;

endmodule

>>> hw/rtl/lik_cordic.sv
module lik_cordic #(
    parameter int STAGES = 18
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [lik_pkg::CORD_W-1:0] x_in,
    input  logic signed [lik_pkg::CORD_W-1:0] y_in,
    output logic signed [lik_pkg::ANG_W-1:0]  angle
);

    localparam int CW = lik_pkg::CORD_W;
    localparam int AW = lik_pkg::ANG_W;
    localparam logic signed [AW-1:0] PI_V = lik_pkg::pi_frac();

    logic signed [CW-1:0] x_s [0:STAGES];
    logic signed [CW-1:0] y_s [0:STAGES];
    logic signed [AW-1:0] a_s [0:STAGES];
    logic                 z_s [0:STAGES];

    logic signed [CW-1:0] x0_reg;
    logic signed [CW-1:0] x0_next;
    logic signed [CW-1:0] y0_reg;
    logic signed [CW-1:0] y0_next;
    logic signed [AW-1:0] a0_reg;
    logic signed [AW-1:0] a0_next;
    logic                 z0_reg;

    // A vector in the left half plane is turned by half a turn first.
    always_comb
    begin
        x0_next = x_in;
        y0_next = y_in;
        a0_next = '0;
        if (x_in < 0)
        begin
            x0_next = -x_in;
            y0_next = -y_in;
            a0_next = (y_in >= 0) ? PI_V : -PI_V;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            a0_reg <= a0_next;
            z0_reg <= (x_in == '0) && (y_in == '0);
        end
    end

    assign x_s[0] = x0_reg;
    assign y_s[0] = y0_reg;
    assign a_s[0] = a0_reg;
    assign z_s[0] = z0_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] STEP = lik_pkg::atan_step(i);

        logic signed [CW-1:0] x_reg;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_reg;
        logic signed [CW-1:0] y_next;
        logic signed [AW-1:0] a_reg;
        logic signed [AW-1:0] a_next;
        logic                 z_reg;

        always_comb
        begin
            if (y_s[i] > 0)
            begin
                x_next = x_s[i] + (y_s[i] >>> i);
                y_next = y_s[i] - (x_s[i] >>> i);
                a_next = a_s[i] + STEP;
            end
            else
            begin
                x_next = x_s[i] - (y_s[i] >>> i);
                y_next = y_s[i] + (x_s[i] >>> i);
                a_next = a_s[i] - STEP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                a_reg <= a_next;
                z_reg <= z_s[i];
            end
        end

        assign x_s[i+1] = x_reg;
        assign y_s[i+1] = y_reg;
        assign a_s[i+1] = a_reg;
        assign z_s[i+1] = z_reg;
    end

    assign angle = z_s[STAGES] ? '0 : a_s[STAGES];

endmodule

>>> hw/rtl/leg_inverse_kinematics_3dof_unit.sv
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_stall   in_data   (tip_x, tip_y, tip_z)
// out       result     out_valid / out_stall out_data  (three angles, reachable)
// cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One target is taken in every cycle while in_stall is low; each request
// passes through the two root chains, the divider chain and the CORDIC chains
// in series. Reset clears the configuration registers to their defaults and
// empties the pipeline. While a result waits under out_stall the whole
// pipeline holds and in_stall is raised.
module leg_inverse_kinematics_3dof_unit #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lik_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lik_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lik_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lik_pkg::REG_W-1:0]         cfg_data
);

    localparam int FB    = lik_pkg::FRAC_BITS;
    localparam int IW    = lik_pkg::IO_W;
    localparam int RGW   = lik_pkg::REG_W;
    localparam int CW    = lik_pkg::CORD_W;
    localparam int AW    = lik_pkg::ANG_W;
    localparam int LN    = IW + 1;
    localparam int LRW   = 2 * LN;
    localparam int AN    = FB + 1;
    localparam int ARW   = 2 * AN;
    localparam int DW    = LRW;
    localparam int CCW   = FB + 2;
    localparam int TLW   = RGW + LN;
    localparam int TTW   = 2 * RGW;
    localparam int NUM_W = LRW + 3;
    localparam int TW    = AW + 3;

    localparam int ST_L     = 3 + LN;
    localparam int ST_DIV   = ST_L + 3;
    localparam int ST_Q     = ST_DIV + FB;
    localparam int ST_C     = ST_Q + 1;
    localparam int ST_RAD   = ST_C + 2;
    localparam int ST_S     = ST_RAD + AN;
    localparam int ST_F     = ST_S + 1 + CORDIC_STAGES;
    localparam int ST_HIP   = 2 + CORDIC_STAGES;
    localparam int ST_ALPHA = ST_L + 1 + CORDIC_STAGES;

    localparam logic signed [TW-1:0] SAT_HI = TW'((1 << (IW - 1)) - 1);
    localparam logic signed [TW-1:0] SAT_LO = -TW'(1 << (IW - 1));

    typedef struct packed {
        logic one;
        logic minus;
        logic neg;
    } cos_flag_t;

    localparam int FLW = $bits(cos_flag_t);

    function automatic cos_flag_t cos_flags(input logic signed [NUM_W-1:0] num,
                                            input logic [DW-1:0] den);
        logic signed [NUM_W-1:0] den_s;
        cos_flag_t               f;
        den_s   = $signed(NUM_W'(den));
        f.one   = (den == '0) || (num >= den_s);
        f.minus = !f.one && (-num >= den_s);
        f.neg   = num < 0;
        return f;
    endfunction

    function automatic logic [DW-1:0] cos_mag(input logic signed [NUM_W-1:0] num);
        logic signed [NUM_W-1:0] m;
        m = (num < 0) ? -num : num;
        return m[DW-1:0];
    endfunction

    function automatic logic signed [CCW-1:0] cos_value(input cos_flag_t f,
                                                        input logic [FB-1:0] q);
        logic signed [CCW-1:0] one_v;
        logic signed [CCW-1:0] q_v;
        one_v = $signed(CCW'(1) << FB);
        q_v   = $signed(CCW'(q));
        if (f.one)
        begin
            return one_v;
        end
        if (f.minus)
        begin
            return -one_v;
        end
        return f.neg ? -q_v : q_v;
    endfunction

    function automatic logic signed [IW-1:0] sat_angle(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[IW-1:0];
    endfunction

    logic adv;

    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Configuration registers

    logic [RGW-1:0] gh_reg;
    logic [RGW-1:0] hip_reg;
    logic [RGW-1:0] thigh_reg;
    logic [RGW-1:0] shank_reg;
    logic [RGW-1:0] tbias_reg;
    logic [RGW-1:0] sbias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gh_reg    <= lik_pkg::RST_GROUND_HEIGHT;
            hip_reg   <= lik_pkg::RST_HIP_LEN;
            thigh_reg <= lik_pkg::RST_THIGH_LEN;
            shank_reg <= lik_pkg::RST_SHANK_LEN;
            tbias_reg <= lik_pkg::RST_THIGH_BIAS;
            sbias_reg <= lik_pkg::RST_SHANK_BIAS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lik_pkg::CFG_GROUND_HEIGHT: gh_reg    <= cfg_data;
                lik_pkg::CFG_HIP_LEN:       hip_reg   <= cfg_data;
                lik_pkg::CFG_THIGH_LEN:     thigh_reg <= cfg_data;
                lik_pkg::CFG_SHANK_LEN:     shank_reg <= cfg_data;
                lik_pkg::CFG_THIGH_BIAS:    tbias_reg <= cfg_data;
                lik_pkg::CFG_SHANK_BIAS:    sbias_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Valid line

    logic valid_last;

    lik_delay #(.W(1), .DEPTH(ST_F + 1)) u_valid_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (in_valid),
        .q     (valid_last)
    );

    assign out_valid = valid_last;

    // Stage 1: offsets

    logic signed [IW-1:0] x1_reg;
    logic signed [IW-1:0] y1_reg;
    logic signed [LN-1:0] dx1_reg;
    logic signed [LN-1:0] dz1_reg;
    logic signed [LN:0]   zs_w;
    logic signed [LN:0]   dz_w;
    logic signed [LN-1:0] dx_w;

    // The ground height is added and removed again, so it cancels exactly.
    always_comb
    begin
        zs_w = (LN+1)'(in_data.tip_z) + $signed((LN+1)'(gh_reg));
        dz_w = $signed((LN+1)'(gh_reg)) - zs_w;
        dx_w = LN'(in_data.tip_x) - $signed(LN'(hip_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= in_data.tip_x;
            y1_reg  <= in_data.tip_y;
            dx1_reg <= dx_w;
            dz1_reg <= dz_w[LN-1:0];
        end
    end

    // Stage 2: squares

    logic [LRW-1:0] xx2_reg;
    logic [LRW-1:0] yy2_reg;
    logic [LRW-1:0] dxx2_reg;
    logic [LRW-1:0] dzz2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx2_reg  <= LRW'(x1_reg) * LRW'(x1_reg);
            yy2_reg  <= LRW'(y1_reg) * LRW'(y1_reg);
            dxx2_reg <= LRW'(dx1_reg) * LRW'(dx1_reg);
            dzz2_reg <= LRW'(dz1_reg) * LRW'(dz1_reg);
        end
    end

    // Stage 3: radicands

    logic [LRW-1:0] rad_l3_reg;
    logic [LRW-1:0] rad_r3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_l3_reg <= dxx2_reg + dzz2_reg;
            rad_r3_reg <= xx2_reg + yy2_reg;
        end
    end

    // Reach and planar radius roots

    logic [LRW-1:0] sl_rem [0:LN];
    logic [LRW:0]   sl_res [0:LN];
    logic [LRW-1:0] sr_rem [0:LN];
    logic [LRW:0]   sr_res [0:LN];

    assign sl_rem[0] = rad_l3_reg;
    assign sl_res[0] = '0;
    assign sr_rem[0] = rad_r3_reg;
    assign sr_res[0] = '0;

    for (genvar j = 0; j < LN; j++)
    begin : g_root_l
        lik_sqrt_cell #(.RW(LRW), .K(LN - 1 - j)) u_cell_l (
            .clk     (clk),
            .en      (adv),
            .rem_in  (sl_rem[j]),
            .res_in  (sl_res[j]),
            .rem_out (sl_rem[j+1]),
            .res_out (sl_res[j+1])
        );
        lik_sqrt_cell #(.RW(LRW), .K(LN - 1 - j)) u_cell_r (
            .clk     (clk),
            .en      (adv),
            .rem_in  (sr_rem[j]),
            .res_in  (sr_res[j]),
            .rem_out (sr_rem[j+1]),
            .res_out (sr_res[j+1])
        );
    end

    logic [LN-1:0] l_w;
    logic [LN-1:0] r_w;

    assign l_w = sl_res[LN][LN-1:0];
    assign r_w = sr_res[LN][LN-1:0];

    logic [LN-1:0] dz_d;

    lik_delay #(.W(LN), .DEPTH(ST_L - 1)) u_dz_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (dz1_reg),
        .q     (dz_d)
    );

    // Hip angle and elevation

    logic signed [AW-1:0] hip_ang;
    logic signed [AW-1:0] alpha_ang;
    logic signed [CW-1:0] alpha_x;

    assign alpha_x = $signed(CW'(r_w)) - $signed(CW'(hip_reg));

    lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hip (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'(x1_reg)),
        .y_in  (CW'(y1_reg)),
        .angle (hip_ang)
    );

    lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_alpha (
        .clk   (clk),
        .en    (adv),
        .x_in  (alpha_x),
        .y_in  (CW'($signed(dz_d))),
        .angle (alpha_ang)
    );

    // Law of cosines terms

    logic [LRW-1:0] ll25_reg;
    logic [TLW-1:0] tl25_reg;
    logic [TTW-1:0] tt25_reg;
    logic [TTW-1:0] ss25_reg;
    logic [TTW-1:0] ts25_reg;
    logic           reach25_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ll25_reg    <= LRW'(l_w) * LRW'(l_w);
            tl25_reg    <= TLW'(thigh_reg) * TLW'(l_w);
            tt25_reg    <= TTW'(thigh_reg) * TTW'(thigh_reg);
            ss25_reg    <= TTW'(shank_reg) * TTW'(shank_reg);
            ts25_reg    <= TTW'(thigh_reg) * TTW'(shank_reg);
            reach25_reg <= l_w <= (LN'(thigh_reg) + LN'(shank_reg));
        end
    end

    logic signed [NUM_W-1:0] nb26_reg;
    logic signed [NUM_W-1:0] ng26_reg;
    logic [DW-1:0]           db26_reg;
    logic [DW-1:0]           dg26_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nb26_reg <= $signed(NUM_W'(tt25_reg)) - $signed(NUM_W'(ss25_reg))
                      + $signed(NUM_W'(ll25_reg));
            ng26_reg <= $signed(NUM_W'(tt25_reg)) + $signed(NUM_W'(ss25_reg))
                      - $signed(NUM_W'(ll25_reg));
            db26_reg <= DW'({tl25_reg, 1'b0});
            dg26_reg <= DW'({ts25_reg, 1'b0});
        end
    end

    // Clamping and divider set-up

    cos_flag_t     fb27_reg;
    cos_flag_t     fg27_reg;
    logic [DW-1:0] rb27_reg;
    logic [DW-1:0] rg27_reg;
    logic [DW-1:0] db27_reg;
    logic [DW-1:0] dg27_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fb27_reg <= cos_flags(nb26_reg, db26_reg);
            fg27_reg <= cos_flags(ng26_reg, dg26_reg);
            rb27_reg <= cos_mag(nb26_reg);
            rg27_reg <= cos_mag(ng26_reg);
            db27_reg <= db26_reg;
            dg27_reg <= dg26_reg;
        end
    end

    logic [DW-1:0] vb_rem [0:FB];
    logic [DW-1:0] vb_d   [0:FB];
    logic [FB-1:0] vb_q   [0:FB];
    logic [DW-1:0] vg_rem [0:FB];
    logic [DW-1:0] vg_d   [0:FB];
    logic [FB-1:0] vg_q   [0:FB];

    assign vb_rem[0] = rb27_reg;
    assign vb_d[0]   = db27_reg;
    assign vb_q[0]   = '0;
    assign vg_rem[0] = rg27_reg;
    assign vg_d[0]   = dg27_reg;
    assign vg_q[0]   = '0;

    for (genvar j = 0; j < FB; j++)
    begin : g_div
        lik_div_cell #(.DW(DW), .QW(FB)) u_cell_b (
            .clk     (clk),
            .en      (adv),
            .rem_in  (vb_rem[j]),
            .d_in    (vb_d[j]),
            .q_in    (vb_q[j]),
            .rem_out (vb_rem[j+1]),
            .d_out   (vb_d[j+1]),
            .q_out   (vb_q[j+1])
        );
        lik_div_cell #(.DW(DW), .QW(FB)) u_cell_g (
            .clk     (clk),
            .en      (adv),
            .rem_in  (vg_rem[j]),
            .d_in    (vg_d[j]),
            .q_in    (vg_q[j]),
            .rem_out (vg_rem[j+1]),
            .d_out   (vg_d[j+1]),
            .q_out   (vg_q[j+1])
        );
    end

    logic [2*FLW-1:0] flags_d;
    cos_flag_t        fb_d;
    cos_flag_t        fg_d;

    lik_delay #(.W(2 * FLW), .DEPTH(FB)) u_flag_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({fb27_reg, fg27_reg}),
        .q     (flags_d)
    );

    assign fb_d = flags_d[2*FLW-1:FLW];
    assign fg_d = flags_d[FLW-1:0];

    // Cosines, then sine by root

    logic signed [CCW-1:0] cb44_reg;
    logic signed [CCW-1:0] cg44_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cb44_reg <= cos_value(fb_d, vb_q[FB]);
            cg44_reg <= cos_value(fg_d, vg_q[FB]);
        end
    end

    logic [2*FB:0] ccb45_reg;
    logic [2*FB:0] ccg45_reg;
    logic signed [2*CCW-1:0] pb_w;
    logic signed [2*CCW-1:0] pg_w;

    assign pb_w = (2*CCW)'(cb44_reg) * (2*CCW)'(cb44_reg);
    assign pg_w = (2*CCW)'(cg44_reg) * (2*CCW)'(cg44_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ccb45_reg <= pb_w[2*FB:0];
            ccg45_reg <= pg_w[2*FB:0];
        end
    end

    logic [ARW-1:0] radb46_reg;
    logic [ARW-1:0] radg46_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            radb46_reg <= (ARW'(1) << (2 * FB)) - ARW'(ccb45_reg);
            radg46_reg <= (ARW'(1) << (2 * FB)) - ARW'(ccg45_reg);
        end
    end

    logic [ARW-1:0] qb_rem [0:AN];
    logic [ARW:0]   qb_res [0:AN];
    logic [ARW-1:0] qg_rem [0:AN];
    logic [ARW:0]   qg_res [0:AN];

    assign qb_rem[0] = radb46_reg;
    assign qb_res[0] = '0;
    assign qg_rem[0] = radg46_reg;
    assign qg_res[0] = '0;

    for (genvar j = 0; j < AN; j++)
    begin : g_root_s
        lik_sqrt_cell #(.RW(ARW), .K(AN - 1 - j)) u_cell_b (
            .clk     (clk),
            .en      (adv),
            .rem_in  (qb_rem[j]),
            .res_in  (qb_res[j]),
            .rem_out (qb_rem[j+1]),
            .res_out (qb_res[j+1])
        );
        lik_sqrt_cell #(.RW(ARW), .K(AN - 1 - j)) u_cell_g (
            .clk     (clk),
            .en      (adv),
            .rem_in  (qg_rem[j]),
            .res_in  (qg_res[j]),
            .rem_out (qg_rem[j+1]),
            .res_out (qg_res[j+1])
        );
    end

    logic [2*CCW-1:0] c_d;

    lik_delay #(.W(2 * CCW), .DEPTH(ST_S - ST_C)) u_cos_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({cb44_reg, cg44_reg}),
        .q     (c_d)
    );

    logic signed [AW-1:0] acos_b;
    logic signed [AW-1:0] acos_g;

    lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'($signed(c_d[2*CCW-1:CCW]))),
        .y_in  ($signed(CW'(qb_res[AN][AN-1:0]))),
        .angle (acos_b)
    );

    lik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_g (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'($signed(c_d[CCW-1:0]))),
        .y_in  ($signed(CW'(qg_res[AN][AN-1:0]))),
        .angle (acos_g)
    );

    // Alignment of the early results

    logic [AW-1:0] hip_d;
    logic [AW-1:0] alpha_d;
    logic          reach_d;

    lik_delay #(.W(AW), .DEPTH(ST_F - ST_HIP)) u_hip_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (hip_ang),
        .q     (hip_d)
    );

    lik_delay #(.W(AW), .DEPTH(ST_F - ST_ALPHA)) u_alpha_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (alpha_ang),
        .q     (alpha_d)
    );

    lik_delay #(.W(1), .DEPTH(ST_F - ST_L - 1)) u_reach_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (reach25_reg),
        .q     (reach_d)
    );

    // Output register

    logic signed [TW-1:0] th1_w;
    logic signed [TW-1:0] th2_w;
    logic signed [TW-1:0] th3_w;
    lik_pkg::out_t        out_reg;
    lik_pkg::out_t        out_next;

    always_comb
    begin
        th1_w = TW'($signed(hip_d));
        th2_w = TW'($signed(alpha_d)) + TW'(acos_b) - $signed(TW'(tbias_reg));
        th3_w = TW'(acos_g) - $signed(TW'(sbias_reg));
        out_next = '0;
        if (reach_d)
        begin
            out_next.hip_angle   = sat_angle(th1_w);
            out_next.thigh_angle = sat_angle(th2_w);
            out_next.shank_angle = sat_angle(th3_w);
            out_next.reachable   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input is held back with no result waiting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reachable |->
            out_data.hip_angle == '0 && out_data.thigh_angle == '0 &&
            out_data.shank_angle == '0)
        else $error("An unreachable target carries non-zero angles.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_reg))
        else $error("A waiting result was lost or altered.");

endmodule
